/* hdl/bsta_pkg.sv */
// Package: widths, register indexes and reset values for the burst start time aligner.
`default_nettype none
package bsta_pkg;
   localparam int unsigned SECS_W  = 32;
   localparam int unsigned RATE_W  = 28;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned PROD_W  = SECS_W + RATE_W;
   localparam int unsigned CNT_W   = 61;
   localparam int unsigned OSECS_W = 64;
   localparam int unsigned IDX_W   = 2;

   localparam logic [IDX_W-1:0] REG_SAMPLE_RATE    = 2'd0;
   localparam logic [IDX_W-1:0] REG_DELAY_SAMPLES  = 2'd1;
   localparam logic [IDX_W-1:0] REG_PERIOD_SAMPLES = 2'd2;

   localparam logic [RATE_W-1:0] RATE_RESET   = 28'd100000000;
   localparam logic [WORD_W-1:0] DELAY_RESET  = 32'd1000000;
   localparam logic [WORD_W-1:0] PERIOD_RESET = 32'd1;
endpackage
`default_nettype wire

/* hdl/bsta_div_cell.sv */
// One restoring division step: shift in a dividend bit, subtract when it fits.
`default_nettype none
module bsta_div_cell #(
   parameter int unsigned N = 61,
   parameter int unsigned D = 32,
   parameter int unsigned P = 1
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [N-1:0] in_word,
   input  wire logic [D-1:0] in_rem,
   input  wire logic [D-1:0] in_div,
   input  wire logic [P-1:0] in_side,
   output logic              out_valid,
   output logic [N-1:0]      out_word,
   output logic [D-1:0]      out_rem,
   output logic [D-1:0]      out_div,
   output logic [P-1:0]      out_side
);
   logic [D:0]   trial;
   logic [D:0]   diff;
   logic         fits;
   logic         valid_ff;
   logic [N-1:0] word_ff, word_in;
   logic [D-1:0] rem_ff, rem_in;
   logic [D-1:0] div_ff;
   logic [P-1:0] side_ff;

   always_comb begin
      trial   = {in_rem, in_word[N-1]};
      diff    = trial - {1'b0, in_div};
      fits    = (trial >= {1'b0, in_div});
      rem_in  = fits ? diff[D-1:0] : trial[D-1:0];
      word_in = {in_word[N-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff <= word_in;
      rem_ff  <= rem_in;
      div_ff  <= in_div;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

/* hdl/bsta_div_chain.sv */
// Row of division cells, one quotient bit per cell, one request per cycle.
`default_nettype none
module bsta_div_chain #(
   parameter int unsigned N = 61,
   parameter int unsigned D = 32,
   parameter int unsigned P = 1
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [N-1:0] in_dividend,
   input  wire logic [D-1:0] in_div,
   input  wire logic [P-1:0] in_side,
   output logic              out_valid,
   output logic [N-1:0]      out_quot,
   output logic [D-1:0]      out_rem,
   output logic [D-1:0]      out_div,
   output logic [P-1:0]      out_side
);
   logic         v_s [0:N];
   logic [N-1:0] w_s [0:N];
   logic [D-1:0] r_s [0:N];
   logic [D-1:0] d_s [0:N];
   logic [P-1:0] s_s [0:N];

   assign v_s[0] = in_valid;
   assign w_s[0] = in_dividend;
   assign r_s[0] = '0;
   assign d_s[0] = in_div;
   assign s_s[0] = in_side;

   for (genvar i = 0; i < N; i++) begin : g_cell
      bsta_div_cell #(.N(N), .D(D), .P(P)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_s[i]),
         .in_word   (w_s[i]),
         .in_rem    (r_s[i]),
         .in_div    (d_s[i]),
         .in_side   (s_s[i]),
         .out_valid (v_s[i+1]),
         .out_word  (w_s[i+1]),
         .out_rem   (r_s[i+1]),
         .out_div   (d_s[i+1]),
         .out_side  (s_s[i+1])
      );
   end

   assign out_valid = v_s[N];
   assign out_quot  = w_s[N];
   assign out_rem   = r_s[N];
   assign out_div   = d_s[N];
   assign out_side  = s_s[N];
endmodule
`default_nettype wire

/* hdl/burst_start_time_aligner.sv */
// Burst start time aligner: timestamp to sample count, delay, period round-up, split.
// Stages from start to rsp_strobe: multiply, add, 61 cells of the period remainder
// chain, round-up add, 61 cells of the rate division chain, output.
// Throughput: one request per cycle; busy stays low, every cell stage advances each cycle.
// Reset: synchronous, clears the strobes of all stages and loads register defaults.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
module burst_start_time_aligner
   import bsta_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [SECS_W-1:0]   req_now_secs,
   input  wire logic [RATE_W-1:0]   req_now_ticks,
   input  wire logic                csr_we,
   input  wire logic [IDX_W-1:0]    csr_index,
   input  wire logic [WORD_W-1:0]   csr_wdata,
   output logic                     rsp_strobe,
   output logic [OSECS_W-1:0]       rsp_start_secs,
   output logic [RATE_W-1:0]        rsp_start_ticks,
   output logic                     rsp_overflow
);
   localparam int unsigned SIDE1_W = CNT_W + RATE_W + 1;

   logic [RATE_W-1:0] rate_ff;
   logic [WORD_W-1:0] delay_ff;
   logic [WORD_W-1:0] period_ff;

   logic              v1_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [RATE_W-1:0] ticks1_ff, rate1_ff;
   logic [WORD_W-1:0] delay1_ff, per1_ff;
   logic [RATE_W-1:0] rate_eff;
   logic [WORD_W-1:0] per_eff;

   logic              v2_ff;
   logic [CNT_W-1:0]  cnt2_ff;
   logic              ovf2_ff;
   logic [RATE_W-1:0] rate2_ff;
   logic [WORD_W-1:0] per2_ff;
   logic [64:0]       sum2_in;

   logic               c1_valid;
   logic [CNT_W-1:0]   c1_quot;
   logic [WORD_W-1:0]  c1_rem, c1_div;
   logic [SIDE1_W-1:0] c1_side;
   logic [CNT_W-1:0]   c1_cnt;
   logic [RATE_W-1:0]  c1_rate;
   logic               c1_ovf;

   logic              v3_ff;
   logic [CNT_W-1:0]  cnt3_ff;
   logic              ovf3_ff;
   logic [RATE_W-1:0] rate3_ff;
   logic [WORD_W-1:0] up_amt;
   logic [64:0]       sum3_in;

   logic              c2_valid;
   logic [CNT_W-1:0]  c2_quot;
   logic [RATE_W-1:0] c2_rem, c2_div;
   logic              c2_ovf;

   logic               rsp_strobe_ff;
   logic [OSECS_W-1:0] rsp_secs_ff;
   logic [RATE_W-1:0]  rsp_ticks_ff;
   logic               rsp_ovf_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RATE_RESET;
         delay_ff  <= DELAY_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SAMPLE_RATE:    rate_ff   <= csr_wdata[RATE_W-1:0];
            REG_DELAY_SAMPLES:  delay_ff  <= csr_wdata;
            REG_PERIOD_SAMPLES: period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
      per_eff  = (period_ff == '0) ? WORD_W'(1) : period_ff;
   end

   // multiply seconds by rate
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      prod_ff   <= PROD_W'(req_now_secs) * PROD_W'(rate_eff);
      ticks1_ff <= req_now_ticks;
      delay1_ff <= delay_ff;
      per1_ff   <= per_eff;
      rate1_ff  <= rate_eff;
   end

   // add ticks and delay
   assign sum2_in = {5'd0, prod_ff} + {37'd0, ticks1_ff} + {33'd0, delay1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      cnt2_ff  <= sum2_in[CNT_W-1:0];
      ovf2_ff  <= sum2_in[64];
      rate2_ff <= rate1_ff;
      per2_ff  <= per1_ff;
   end

   bsta_div_chain #(.N(CNT_W), .D(WORD_W), .P(SIDE1_W)) u_mod_chain (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v2_ff),
      .in_dividend (cnt2_ff),
      .in_div      (per2_ff),
      .in_side     ({cnt2_ff, rate2_ff, ovf2_ff}),
      .out_valid   (c1_valid),
      .out_quot    (c1_quot),
      .out_rem     (c1_rem),
      .out_div     (c1_div),
      .out_side    (c1_side)
   );

   assign {c1_cnt, c1_rate, c1_ovf} = c1_side;

   // round up to the period
   always_comb begin
      up_amt  = (c1_rem == '0) ? '0 : (c1_div - c1_rem);
      sum3_in = {4'd0, c1_cnt} + {33'd0, up_amt};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= c1_valid;
      end
      cnt3_ff  <= sum3_in[CNT_W-1:0];
      ovf3_ff  <= c1_ovf | sum3_in[64] | (c1_quot == '1 && 1'b0);
      rate3_ff <= c1_rate;
   end

   bsta_div_chain #(.N(CNT_W), .D(RATE_W), .P(1)) u_split_chain (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v3_ff),
      .in_dividend (cnt3_ff),
      .in_div      (rate3_ff),
      .in_side     (ovf3_ff),
      .out_valid   (c2_valid),
      .out_quot    (c2_quot),
      .out_rem     (c2_rem),
      .out_div     (c2_div),
      .out_side    (c2_ovf)
   );

   // zero the results on overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= c2_valid;
      end
      rsp_secs_ff  <= c2_ovf ? '0 : {{(OSECS_W-CNT_W){1'b0}}, c2_quot};
      rsp_ticks_ff <= (c2_ovf || c2_div == '0) ? '0 : c2_rem;
      rsp_ovf_ff   <= c2_ovf;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_start_secs  = rsp_secs_ff;
   assign rsp_start_ticks = rsp_ticks_ff;
   assign rsp_overflow    = rsp_ovf_ff;
endmodule
`default_nettype wire
